@@ rtl/core/tgt_pkg.sv @@
// Package for the twiddle gain tuner: Q12.20 constants, register and phase codes,
// and saturating and rounding helpers for the Q12.20 gain arithmetic.
// No dependencies.
package tgt_pkg;

   localparam int unsigned GAIN_NUM   = 3;
   localparam int unsigned Q_FRAC     = 20;
   localparam int unsigned ADDR_W     = 5;

   // growth 1.1 and shrink 0.9 in Q.20
   localparam logic signed [21:0] GROW_Q20   = 22'sd1153434;
   localparam logic signed [21:0] SHRINK_Q20 = 22'sd943718;

   localparam logic signed [31:0] STEP_P_RESET = 32'sd314573;   // 0.3
   localparam logic signed [31:0] STEP_I_RESET = 32'sd1049;     // 0.001
   localparam logic signed [31:0] STEP_D_RESET = 32'sd314573;   // 0.3
   localparam logic signed [33:0] STEP_SUM_RESET = 34'sd630195;
   localparam logic [30:0]        TOL_RESET    = 31'd105;       // ~0.0001
   localparam logic signed [31:0] BEST_RESET   = 32'sh7FFF_FFFF;

   localparam logic signed [33:0] S32_MAX = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] S32_MIN = 34'sh3_8000_0000;

   typedef enum logic [2:0] {
      CSR_GAIN_P = 3'd0,
      CSR_GAIN_I = 3'd1,
      CSR_GAIN_D = 3'd2,
      CSR_BEST   = 3'd3,
      CSR_TOL    = 3'd4
   } csr_idx_type;

   // probe up, then check/probe down, then settle; code 3 never occurs
   typedef enum logic [1:0] {
      PH_PROBE = 2'd0,
      PH_CHECK = 2'd1,
      PH_RETRY = 2'd2
   } phase_type;

   function automatic logic signed [31:0] step_reset(input logic [1:0] idx);
      logic signed [31:0] v;
      unique case (idx)
         2'd0:    v = STEP_P_RESET;
         2'd1:    v = STEP_I_RESET;
         default: v = STEP_D_RESET;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < S32_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // product / 2^20, rounded to nearest with ties away from zero, saturated
   function automatic logic signed [31:0] scale_round(input logic signed [53:0] p);
      logic        neg;
      logic [53:0] mag;
      logic [53:0] sum;
      logic [32:0] rnd;
      logic [32:0] nrnd;
      logic signed [31:0] r;
      neg  = p[53];
      mag  = neg ? 54'(-p) : 54'(p);
      sum  = mag + (54'd1 << (Q_FRAC - 1));
      rnd  = sum[Q_FRAC +: 33];
      nrnd = 33'(-rnd);
      if (!neg) begin
         r = (rnd > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(rnd[31:0]);
      end else begin
         r = (rnd > 33'h0_8000_0000) ? 32'sh8000_0000 : $signed(nrnd[31:0]);
      end
      return r;
   endfunction

   function automatic logic [32:0] mag33(input logic signed [31:0] v);
      logic signed [32:0] x;
      x = {v[31], v};
      return v[31] ? 33'(-x) : 33'(x);
   endfunction

endpackage

@@ rtl/core/twiddle_gain_tuner.sv @@
// Top level of the twiddle gain tuner: request/response datapath, APB register
// file and the step-size memory. Depends on tgt_pkg.
//
// Twiddle (coordinate ascent) tuner for three PID gains, Q12.20 throughout.
// Each request carries one cross-track error sample and yields exactly one
// response with the three gains after the step, a step_taken bit and the
// sticky tuned flag. One request is taken every clock cycle unless stalled;
// the response appears in the cycle after acceptance from an output register,
// and the input keeps accepting while that register waits, as long as the
// response is taken in the same cycle. The three step sizes live in a
// three-entry memory with a registered read: the entry of the next gain index
// is read ahead every cycle, with a write-through bypass when that entry is
// being updated, and its 1.1x and 0.9x products are registered ahead of use.
// The twiddle sequence guarantees that a request which scales a step is
// always preceded by one that leaves that step untouched, so the products are
// ready in time. Step entries never written since reset read as their reset
// values (valid bits), so no clearing pass is needed. The sum of step sizes is
// kept as a running total. Writing an initial gain or initial best error also
// loads the live value; registers must only be written while the block is idle.
module twiddle_gain_tuner
   import tgt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [31:0]        req_track_error,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [31:0]        rsp_gain_p,
   output logic signed [31:0]        rsp_gain_i,
   output logic signed [31:0]        rsp_gain_d,
   output logic                      rsp_step_taken,
   output logic                      rsp_tuned,
   // register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [ADDR_W-1:0]         paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   // ---------------------------------------------------------------- state
   logic signed [31:0] reg_gain_ff [GAIN_NUM];
   logic signed [31:0] reg_best_ff;
   logic [30:0]        tol_ff;

   logic signed [31:0] gains_ff [GAIN_NUM];
   logic signed [31:0] gains_in [GAIN_NUM];
   logic signed [31:0] best_ff, best_in;
   phase_type          phase_ff, phase_in;
   logic [1:0]         idx_ff, idx_in;
   logic               tuned_ff, tuned_in;
   logic signed [33:0] total_ff, total_in;    // running sum of step sizes

   // step-size memory and its read-ahead port
   logic signed [31:0] step_mem [GAIN_NUM];
   logic [GAIN_NUM-1:0] step_vld_ff;
   logic               step_we;
   logic [1:0]         step_waddr;
   logic signed [31:0] step_wdata;
   logic [1:0]         rd_addr;
   logic [1:0]         rd_addr_ff;
   logic signed [31:0] mem_q_ff;
   logic               rd_hit_ff;          // entry was valid when read
   logic               fwd_ff;             // write to the same entry bypassed
   logic signed [31:0] fwd_data_ff;
   logic signed [31:0] step_k;

   logic signed [53:0] grow_prod_ff, shrink_prod_ff;
   logic signed [31:0] grow_val, shrink_val;

   // response register
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_gain_ff [GAIN_NUM];
   logic               rsp_taken_ff;
   logic               rsp_tuned_ff;

   // ---------------------------------------------------------------- handshakes
   logic        req_fire;
   logic        cfg_we;
   csr_idx_type cfg_idx;
   logic [1:0]  k;
   logic        take;
   logic        better;
   logic signed [31:0] gain_k;
   logic signed [31:0] new_step;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign pready    = 1'b1;
   assign cfg_we    = psel && penable && pwrite && pready;
   assign cfg_idx   = csr_idx_type'(paddr[4:2]);

   // a stray gain index of 3 is served as index 0
   assign k      = (idx_ff == 2'd3) ? 2'd0 : idx_ff;
   assign gain_k = gains_ff[k];

   // step size of the current gain: bypass, then memory, then reset value
   assign step_k = fwd_ff    ? fwd_data_ff :
                   rd_hit_ff ? mem_q_ff    : step_reset(rd_addr_ff);

   assign grow_val   = scale_round(grow_prod_ff);
   assign shrink_val = scale_round(shrink_prod_ff);

   // skip unless steps still sum above tolerance or the error is nonzero
   assign take   = (total_ff > $signed({3'b000, tol_ff})) || (req_track_error != 32'sd0);
   assign better = mag33(req_track_error) < mag33(best_ff);

   // ---------------------------------------------------------------- next state
   always_comb begin
      gains_in   = gains_ff;
      best_in    = best_ff;
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      tuned_in   = tuned_ff;
      total_in   = total_ff;
      step_we    = 1'b0;
      step_waddr = k;
      new_step   = grow_val;

      if (req_fire && take) begin
         unique case (phase_ff)
            PH_PROBE: begin
               gains_in[k] = sat32(34'(gain_k) + 34'(step_k));
               phase_in    = PH_CHECK;
            end
            PH_CHECK: begin
               if (better) begin
                  best_in  = req_track_error;
                  step_we  = 1'b1;
                  new_step = grow_val;
               end else begin
                  gains_in[k] = sat32(34'(gain_k) - (34'(step_k) <<< 1));
                  phase_in    = PH_RETRY;
               end
               if (better) begin
                  phase_in = PH_PROBE;
               end
            end
            PH_RETRY: begin
               step_we = 1'b1;
               if (better) begin
                  best_in  = req_track_error;
                  new_step = grow_val;
                  tuned_in = 1'b1;
               end else begin
                  gains_in[k] = sat32(34'(gain_k) + 34'(step_k));
                  new_step    = shrink_val;
               end
               phase_in = PH_PROBE;
               idx_in   = (k == 2'd2) ? 2'd0 : k + 2'd1;
            end
            default: begin
               phase_in = PH_PROBE;
               idx_in   = (k == 2'd2) ? 2'd0 : k + 2'd1;
            end
         endcase
      end

      if (step_we) begin
         total_in = total_ff - 34'(step_k) + 34'(new_step);
      end

      // the user must write registers only while idle; the block does not enforce it
      if (cfg_we) begin
         unique case (cfg_idx)
            CSR_GAIN_P: gains_in[0] = $signed(pwdata);
            CSR_GAIN_I: gains_in[1] = $signed(pwdata);
            CSR_GAIN_D: gains_in[2] = $signed(pwdata);
            CSR_BEST:   best_in     = $signed(pwdata);
            default: ;
         endcase
      end
   end

   assign step_wdata = new_step;
   assign rd_addr    = (idx_in == 2'd3) ? 2'd0 : idx_in;

   // ---------------------------------------------------------------- phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PROBE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // ---------------------------------------------------------------- tuner state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GAIN_NUM; i++) begin
            gains_ff[i] <= 32'sd0;
         end
         best_ff  <= BEST_RESET;
         idx_ff   <= 2'd0;
         tuned_ff <= 1'b0;
         total_ff <= STEP_SUM_RESET;
      end else begin
         gains_ff <= gains_in;
         best_ff  <= best_in;
         idx_ff   <= idx_in;
         tuned_ff <= tuned_in;
         total_ff <= total_in;
      end
   end

   // ---------------------------------------------------------------- step memory
   always_ff @(posedge clock) begin
      if (step_we) begin
         step_mem[step_waddr] <= step_wdata;
      end
      mem_q_ff    <= step_mem[rd_addr];
      fwd_data_ff <= step_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_vld_ff <= '0;
         rd_addr_ff  <= 2'd0;
         rd_hit_ff   <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (step_we) begin
            step_vld_ff[step_waddr] <= 1'b1;
         end
         rd_addr_ff <= rd_addr;
         rd_hit_ff  <= step_vld_ff[rd_addr];
         fwd_ff     <= step_we && (step_waddr == rd_addr);
      end
   end

   // products of the current step, registered ahead of use
   always_ff @(posedge clock) begin
      grow_prod_ff   <= step_k * GROW_Q20;
      shrink_prod_ff <= step_k * SHRINK_Q20;
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GAIN_NUM; i++) begin
            reg_gain_ff[i] <= 32'sd0;
         end
         reg_best_ff <= BEST_RESET;
         tol_ff      <= TOL_RESET;
      end else if (cfg_we) begin
         unique case (cfg_idx)
            CSR_GAIN_P: reg_gain_ff[0] <= $signed(pwdata);
            CSR_GAIN_I: reg_gain_ff[1] <= $signed(pwdata);
            CSR_GAIN_D: reg_gain_ff[2] <= $signed(pwdata);
            CSR_BEST:   reg_best_ff    <= $signed(pwdata);
            CSR_TOL:    tol_ff         <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         CSR_GAIN_P: prdata = reg_gain_ff[0];
         CSR_GAIN_I: prdata = reg_gain_ff[1];
         CSR_GAIN_D: prdata = reg_gain_ff[2];
         CSR_BEST:   prdata = reg_best_ff;
         CSR_TOL:    prdata = {1'b0, tol_ff};
         default:    prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_gain_ff  <= gains_in;
         rsp_taken_ff <= take;
         rsp_tuned_ff <= tuned_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gain_p     = rsp_gain_ff[0];
   assign rsp_gain_i     = rsp_gain_ff[1];
   assign rsp_gain_d     = rsp_gain_ff[2];
   assign rsp_step_taken = rsp_taken_ff;
   assign rsp_tuned      = rsp_tuned_ff;

endmodule
